FILE: rtl/rxs_pkg.sv
// Package for the record exchange sort block.
// Holds the record type, the state encoding, sizes and the key function.
// Used by rtl/record_exchange_sort_by_total.sv.
package rxs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int TAG_W       = 6;
    localparam int SCORE_W     = 10;
    localparam int TOTAL_W     = 12;
    localparam int REC_W       = TAG_W + 3 * SCORE_W;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] s1;
        logic [SCORE_W-1:0] s2;
        logic [SCORE_W-1:0] s3;
    } t_rec;

    typedef enum logic [2:0] {
        S_LOAD,
        S_LD_I,
        S_CMP,
        S_WB,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    function automatic logic [TOTAL_W-1:0] rec_key(input t_rec r);
        rec_key = TOTAL_W'(r.s1) + TOTAL_W'(r.s2) + TOTAL_W'(r.s3);
    endfunction

endpackage

FILE: rtl/rxs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// The read data holds while the read enable is low. No dependencies.
module rxs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/record_exchange_sort_by_total.sv
// Record exchange sort by total score, top level.
// Depends on rtl/rxs_pkg.sv and rtl/rxs_ram.sv.
//
// Usage: records enter on the input channel (i_valid, o_ready), one word per
// record, and are stored in a 64-entry RAM. Records that arrive when the store
// is full are discarded, and every result of that set then carries o_dropped.
// The word with i_last_in set ends the set and starts the sort; o_ready stays
// low from then until the last result of the set has been placed in the output
// register. Loading accepts a word whenever i_valid is high.
// The sort runs on one comparator and one RAM read port. Each outer pass reads
// record i (S_LD_I), compares the held record with each later record (S_CMP),
// keeps the smaller total and writes the larger back, then stores the held one
// at slot i (S_WB). Results leave on the output channel (o_valid, i_ready), one
// word per cycle while i_ready is high, ascending by o_total, with o_last_out
// on the final word. A stall on i_ready holds the output register and pauses
// the RAM reads. Input words are taken again as soon as the final result sits
// in the output register. Reset clears the record count, the drop flag and the
// output valid; the RAM contents are not cleared and need not be.
module record_exchange_sort_by_total
    import rxs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic [SCORE_W-1:0] i_score_first,
    input  logic [SCORE_W-1:0] i_score_second,
    input  logic [SCORE_W-1:0] i_score_third,
    input  logic               i_last_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TAG_W-1:0]   o_tag_out,
    output logic [SCORE_W-1:0] o_first_out,
    output logic [SCORE_W-1:0] o_second_out,
    output logic [SCORE_W-1:0] o_third_out,
    output logic [TOTAL_W-1:0] o_total,
    output logic               o_last_out,
    output logic               o_dropped
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [ADDR_W-1:0]  r_i, n_i;
    logic [ADDR_W-1:0]  r_j, n_j;
    t_rec               r_hold, n_hold;
    logic               r_out_valid, n_out_valid;
    t_rec               r_out, n_out;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_last, n_out_last;
    logic               r_out_drop, n_out_drop;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_rec              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_rec              rd_data;
    logic [REC_W-1:0]  rd_bits;
    t_rec              in_rec;
    logic [CNT_W-1:0]  cnt_after;
    logic              slot_free;

    rxs_ram #(
        .WIDTH(REC_W),
        .DEPTH(MAX_RECORDS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_bits)
    );

    assign rd_data   = t_rec'(rd_bits);
    assign in_rec    = '{tag: i_tag, s1: i_score_first, s2: i_score_second,
                         s3: i_score_third};
    assign slot_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_i         <= n_i;
        r_j         <= n_j;
        r_hold      <= n_hold;
        r_out       <= n_out;
        r_out_total <= n_out_total;
        r_out_last  <= n_out_last;
        r_out_drop  <= n_out_drop;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        n_out_total = r_out_total;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        wr_en       = 1'b0;
        wr_addr     = r_i;
        wr_data     = r_hold;
        rd_en       = 1'b0;
        rd_addr     = r_j;
        cnt_after   = r_count;
        o_ready     = 1'b0;

        case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (r_count < CNT_W'(MAX_RECORDS)) begin
                        wr_en     = 1'b1;
                        wr_addr   = r_count[ADDR_W-1:0];
                        wr_data   = in_rec;
                        cnt_after = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = cnt_after;
                    if (i_last_in) begin
                        n_n = cnt_after;
                        n_i = '0;
                        n_j = '0;
                        if (cnt_after >= CNT_W'(2)) begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_LD_I;
                        end else begin
                            n_state = S_EMIT_RD;
                        end
                    end
                end
            end
            S_LD_I: begin
                n_hold  = rd_data;
                rd_en   = 1'b1;
                rd_addr = r_i + ADDR_W'(1);
                n_j     = r_i + ADDR_W'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rec_key(r_hold) > rec_key(rd_data)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_j;
                    wr_data = r_hold;
                    n_hold  = rd_data;
                end
                if (CNT_W'(r_j) + CNT_W'(1) == r_n) begin
                    n_state = S_WB;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_j + ADDR_W'(1);
                    n_j     = r_j + ADDR_W'(1);
                end
            end
            S_WB: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_hold;
                if (CNT_W'(r_i) + CNT_W'(2) == r_n) begin
                    n_j     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_i + ADDR_W'(1);
                    n_i     = r_i + ADDR_W'(1);
                    n_state = S_LD_I;
                end
            end
            S_EMIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = rd_data;
                    n_out_total = rec_key(rd_data);
                    n_out_drop  = r_ovf;
                    n_out_last  = (CNT_W'(r_j) + CNT_W'(1) == r_n);
                    if (CNT_W'(r_j) + CNT_W'(1) == r_n) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_j + ADDR_W'(1);
                        n_j     = r_j + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_tag_out    = r_out.tag;
    assign o_first_out  = r_out.s1;
    assign o_second_out = r_out.s2;
    assign o_third_out  = r_out.s3;
    assign o_total      = r_out_total;
    assign o_last_out   = r_out_last;
    assign o_dropped    = r_out_drop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("Record count exceeds the store depth.");

    a_sort_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD_I || r_state == S_CMP || r_state == S_WB)
            |-> r_n >= CNT_W'(2))
        else $error("Sort running on fewer than two records.");

    a_j_after_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> (r_j > r_i && CNT_W'(r_j) < r_n))
        else $error("Compare index out of order or out of range.");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_LOAD)
            |=> (r_count == '0 && !r_ovf && o_valid && o_last_out))
        else $error("Set state not cleared after the final result.");

endmodule

FILE: tb/rxs_sort_checker.sv
// Checker for the record exchange sort block: watches both channels, predicts
// the sorted output of every record set and compares it word by word.
// Depends on rtl/rxs_pkg.sv for the record type and sizes.
module rxs_sort_checker
    import rxs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic [SCORE_W-1:0] i_score_first,
    input  logic [SCORE_W-1:0] i_score_second,
    input  logic [SCORE_W-1:0] i_score_third,
    input  logic               i_last_in,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [TAG_W-1:0]   o_tag_out,
    input  logic [SCORE_W-1:0] o_first_out,
    input  logic [SCORE_W-1:0] o_second_out,
    input  logic [SCORE_W-1:0] o_third_out,
    input  logic [TOTAL_W-1:0] o_total,
    input  logic               o_last_out,
    input  logic               o_dropped,
    output int                 o_mismatches,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_rec               rec;
        logic [TOTAL_W-1:0] total;
        logic               last;
        logic               dropped;
    } t_sorted_word;

    t_rec         shelf [$];
    int           shelf_fill;
    bit           spilled;
    t_sorted_word sorted_q [$];
    int           errors;

    function automatic int record_total(input t_rec r);
        return int'(r.s1) + int'(r.s2) + int'(r.s3);
    endfunction

    task automatic flag_error(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic sort_and_queue();
        t_rec         swap;
        t_sorted_word w;
        for (int i = 0; i + 1 < shelf_fill; i++) begin
            for (int j = i + 1; j < shelf_fill; j++) begin
                if (record_total(shelf[i]) > record_total(shelf[j])) begin
                    swap     = shelf[i];
                    shelf[i] = shelf[j];
                    shelf[j] = swap;
                end
            end
        end
        for (int k = 0; k < shelf_fill; k++) begin
            w.rec     = shelf[k];
            w.total   = TOTAL_W'(record_total(shelf[k]));
            w.last    = (k == shelf_fill - 1);
            w.dropped = spilled;
            sorted_q.push_back(w);
        end
        shelf.delete();
        shelf_fill = 0;
        spilled    = 1'b0;
    endtask

    always @(posedge i_clk) begin : watch
        t_rec         arrived;
        t_sorted_word want;
        if (!i_rst_n) begin
            shelf.delete();
            shelf_fill = 0;
            spilled    = 1'b0;
            sorted_q.delete();
        end else begin
            if (i_valid && o_ready) begin
                arrived = '{tag: i_tag, s1: i_score_first, s2: i_score_second,
                            s3: i_score_third};
                if (shelf_fill < MAX_RECORDS) begin
                    shelf.push_back(arrived);
                    shelf_fill++;
                end else begin
                    spilled = 1'b1;
                end
                if (i_last_in) begin
                    sort_and_queue();
                end
            end
            if (o_valid && i_ready) begin
                if (sorted_q.size() == 0) begin
                    flag_error($sformatf("word with tag %0d arrived with nothing expected",
                                         o_tag_out));
                end else begin
                    want = sorted_q.pop_front();
                    check_field("tag_out", int'(o_tag_out), int'(want.rec.tag));
                    check_field("first_out", int'(o_first_out), int'(want.rec.s1));
                    check_field("second_out", int'(o_second_out), int'(want.rec.s2));
                    check_field("third_out", int'(o_third_out), int'(want.rec.s3));
                    check_field("total", int'(o_total), int'(want.total));
                    check_field("last_out", int'(o_last_out), int'(want.last));
                    check_field("dropped", int'(o_dropped), int'(want.dropped));
                end
            end
        end
        o_pending    <= sorted_q.size();
        o_mismatches <= errors;
    end

endmodule

FILE: tb/record_exchange_sort_by_total_tb.sv
// Top of the record exchange sort testbench: clock, reset, record sets on the
// input channel, a randomly stalling receiver, a watchdog and the verdict.
// Depends on rtl/rxs_pkg.sv, the block itself and tb/rxs_sort_checker.sv.
module record_exchange_sort_by_total_tb;
    import rxs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;
    localparam int WORD_TARGET = 210;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [TAG_W-1:0]   i_tag = '0;
    logic [SCORE_W-1:0] i_score_first = '0;
    logic [SCORE_W-1:0] i_score_second = '0;
    logic [SCORE_W-1:0] i_score_third = '0;
    logic               i_last_in = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [TAG_W-1:0]   o_tag_out;
    logic [SCORE_W-1:0] o_first_out;
    logic [SCORE_W-1:0] o_second_out;
    logic [SCORE_W-1:0] o_third_out;
    logic [TOTAL_W-1:0] o_total;
    logic               o_last_out;
    logic               o_dropped;

    int mismatches;
    int pending;
    int words_sent = 0;
    bit steady_sender = 1'b0;

    record_exchange_sort_by_total DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_tag          (i_tag),
        .i_score_first  (i_score_first),
        .i_score_second (i_score_second),
        .i_score_third  (i_score_third),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tag_out      (o_tag_out),
        .o_first_out    (o_first_out),
        .o_second_out   (o_second_out),
        .o_third_out    (o_third_out),
        .o_total        (o_total),
        .o_last_out     (o_last_out),
        .o_dropped      (o_dropped)
    );

    rxs_sort_checker sort_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_tag          (i_tag),
        .i_score_first  (i_score_first),
        .i_score_second (i_score_second),
        .i_score_third  (i_score_third),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tag_out      (o_tag_out),
        .o_first_out    (o_first_out),
        .o_second_out   (o_second_out),
        .o_third_out    (o_third_out),
        .o_total        (o_total),
        .o_last_out     (o_last_out),
        .o_dropped      (o_dropped),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return SCORE_W'($urandom_range(4) * 250);
            default: return SCORE_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic send_word(input int tag, input int first, input int second,
                             input int third, input bit last);
        while (!steady_sender && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_tag          <= TAG_W'(tag);
        i_score_first  <= SCORE_W'(first);
        i_score_second <= SCORE_W'(second);
        i_score_third  <= SCORE_W'(third);
        i_last_in      <= last;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int set_no;
        int set_len;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lone records at both ends of the key range.
        send_word(0, 0, 0, 0, 1'b1);
        send_word(63, 1023, 1023, 1023, 1'b1);
        // Equal totals, then a mixed set with ties and alternating bit patterns.
        send_word(1, 1000, 0, 0, 1'b0);
        send_word(2, 0, 1000, 0, 1'b0);
        send_word(3, 0, 0, 1000, 1'b1);
        send_word(4, 900, 900, 900, 1'b0);
        send_word(5, 300, 300, 300, 1'b0);
        send_word(6, 0, 0, 0, 1'b0);
        send_word(7, 300, 300, 300, 1'b0);
        send_word(8, 682, 341, 0, 1'b0);
        send_word(9, 10, 20, 30, 1'b1);
        // Already ascending, then descending.
        send_word(10, 1, 2, 3, 1'b0);
        send_word(11, 4, 5, 6, 1'b1);
        send_word(12, 600, 0, 0, 1'b0);
        send_word(13, 500, 0, 0, 1'b1);

        // Set 3 fills the store exactly; set 8 overflows it, the last word dropped too.
        set_no = 0;
        while (words_sent < WORD_TARGET) begin
            set_len = (set_no == 3) ? MAX_RECORDS :
                      (set_no == 8) ? MAX_RECORDS + 2 : $urandom_range(1, 10);
            steady_sender = (set_no >= 9 && set_no < 13);
            for (int k = 0; k < set_len; k++) begin
                send_word($urandom_range(63), int'(pick_score()), int'(pick_score()),
                          int'(pick_score()), k == set_len - 1);
            end
            if (set_no == 5) begin
                drain_results();
            end
            set_no++;
        end
        steady_sender = 1'b0;

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("record_exchange_sort_by_total_tb OK");
        end else begin
            $display("record_exchange_sort_by_total_tb NOT OK");
        end
        $finish;
    end

    initial begin : receiver
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                taken++;
            end
            if (!held && taken == 20) begin
                held = 1'b1;
                for (int k = 0; k < 300; k++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end else if (taken >= 120 && taken < 190) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 6);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns  no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("record_exchange_sort_by_total_tb NOT OK");
        $finish;
    end

endmodule
